FILE: design/sgli_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared constants, codes and types of the sorted-grid linear interpolator.
// No dependencies.
package sgli_pkg;
	localparam int TABLE_DEPTH = 256;
	localparam int FRAC_BITS   = 16;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int POS_W       = 32;
	localparam int WORD_W      = 2 * POS_W;

	typedef logic [1:0]  kind_t;
	typedef logic [2:0]  status_t;
	typedef logic [15:0] weight_t;
	typedef logic [7:0]  slot_t;
	typedef logic signed [POS_W-1:0] fix_t;

	localparam kind_t KIND_LOAD  = 2'd0;
	localparam kind_t KIND_QUERY = 2'd1;
	localparam kind_t KIND_CLEAR = 2'd2;

	localparam status_t ST_LOADED   = 3'd0;
	localparam status_t ST_REJECTED = 3'd1;
	localparam status_t ST_CLEARED  = 3'd2;
	localparam status_t ST_EXACT    = 3'd3;
	localparam status_t ST_INTERP   = 3'd4;
	localparam status_t ST_OUTRANGE = 3'd5;
	localparam status_t ST_EMPTY    = 3'd6;
endpackage
`default_nettype wire

FILE: design/sgli_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Request channel: valid/ready with kind, position and sample value.
// Depends on sgli_pkg.
interface sgli_req_if;
	logic               valid;
	logic               ready;
	sgli_pkg::kind_t    kind;
	sgli_pkg::fix_t     position;
	sgli_pkg::fix_t     sample_value;
	modport source (output valid, kind, position, sample_value, input ready);
	modport sink (input valid, kind, position, sample_value, output ready);
endinterface
`default_nettype wire

FILE: design/sgli_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Result channel: valid/ready with status, weight, value and slot.
// Depends on sgli_pkg.
interface sgli_rsp_if;
	logic               valid;
	logic               ready;
	sgli_pkg::status_t  status;
	sgli_pkg::weight_t  weight_fraction;
	sgli_pkg::fix_t     interpolated_value;
	sgli_pkg::slot_t    lower_slot;
	modport source (output valid, status, weight_fraction, interpolated_value, lower_slot,
		input ready);
	modport sink (input valid, status, weight_fraction, interpolated_value, lower_slot,
		output ready);
endinterface
`default_nettype wire

FILE: design/sgli_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sgli_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule
`default_nettype wire

FILE: design/sgli_divmul.sv
`timescale 1ns / 1ps
`default_nettype none
// Bit-serial fraction divider with a merged Horner multiply-accumulate.
// Depends on sgli_pkg.
module sgli_divmul (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [sgli_pkg::POS_W-1:0]  num,
	input  logic [sgli_pkg::POS_W-1:0]  den,
	input  logic signed [sgli_pkg::POS_W:0] diff,
	input  sgli_pkg::fix_t              base,
	output logic                        done,
	output sgli_pkg::weight_t           weight,
	output sgli_pkg::fix_t              value
);
	import sgli_pkg::*;

	localparam int ACC_W  = POS_W + 1 + FRAC_BITS + 1;
	localparam int STEP_W = $clog2(FRAC_BITS + 1);

	logic                     busy_q, fin_q, done_q;
	logic [STEP_W-1:0]        cnt_q;
	logic [POS_W-1:0]         rem_q, den_q;
	logic signed [POS_W:0]    diff_q;
	fix_t                     base_q, value_q;
	logic [FRAC_BITS-1:0]     frac_q;
	logic signed [ACC_W-1:0]  acc_q;

	logic [POS_W:0]           r2;
	logic                     ge;
	logic signed [ACC_W:0]    total;
	logic signed [ACC_W:0]    fl;
	logic                     bump;

	always_comb begin
		r2    = {rem_q, 1'b0};
		ge    = r2 >= {1'b0, den_q};
		total = ({{(ACC_W + 1 - POS_W){base_q[POS_W-1]}}, base_q} <<< FRAC_BITS)
			+ {acc_q[ACC_W-1], acc_q};
		fl    = total >>> FRAC_BITS;
		bump  = total[ACC_W] && (total[FRAC_BITS-1:0] != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_W'(FRAC_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	// One quotient bit per cycle, MSB first; the product c*diff builds up alongside.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num;
			den_q  <= den;
			diff_q <= diff;
			base_q <= base;
			acc_q  <= '0;
			frac_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? POS_W'(r2 - {1'b0, den_q}) : r2[POS_W-1:0];
			frac_q <= {frac_q[FRAC_BITS-2:0], ge};
			acc_q  <= (acc_q <<< 1)
				+ (ge ? {{(ACC_W - POS_W - 1){diff_q[POS_W]}}, diff_q} : '0);
		end
		if (fin_q) begin
			value_q <= POS_W'(fl + (ACC_W + 1)'(bump));
		end
	end

	assign done   = done_q;
	assign weight = 16'(frac_q);
	assign value  = value_q;
endmodule
`default_nettype wire

FILE: design/sorted_grid_linear_interpolator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Top level of the sorted-grid linear interpolator.
// Depends on sgli_pkg, sgli_req_if, sgli_rsp_if, sgli_ram, sgli_divmul.

// The block keeps up to TABLE_DEPTH points (position, sample) in one RAM, loaded in
// strictly ascending position order, and answers one result per request. Load, clear
// and unused kinds go straight to the output state. A query outside the span, or on an
// empty table, does too, since the first and last positions are held in registers. An
// in-span query binary-searches the RAM, probing through its registered
// read port (at most log2 of the point count, rounded up, probes), then reads the
// first point at or above the query; on an exact match it is done, else it reads the
// lower neighbor and runs the bit-serial divider that yields one fraction bit per cycle
// together with the weighted sum.
// One request is in work at a time; a finished result waits in the output register
// while the next request is already taken.
module sorted_grid_linear_interpolator_core (
	input  logic clk,
	input  logic arst_n,
	sgli_req_if.sink   req,
	sgli_rsp_if.source rsp
);
	import sgli_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_SRCH = 7'b0000010,
		S_SCMP = 7'b0000100,
		S_HIT  = 7'b0001000,
		S_LOW  = 7'b0010000,
		S_DIV  = 7'b0100000,
		S_OUT  = 7'b1000000
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	fix_t              first_q, last_q, x_q;
	logic [IDX_W-1:0]  lo_q, hi_q, mid_q;
	fix_t              up_pos_q, up_smp_q;

	status_t           res_status_q;
	weight_t           res_weight_q;
	fix_t              res_value_q;
	slot_t             res_slot_q;

	logic              out_valid_q;
	status_t           out_status_q;
	weight_t           out_weight_q;
	fix_t              out_value_q;
	slot_t             out_slot_q;

	logic              accept;
	logic              load_ok;
	logic [IDX_W-1:0]  mid;
	logic [IDX_W-1:0]  rd_addr;
	logic [WORD_W-1:0] rd_data;
	fix_t              rd_pos, rd_smp;
	logic              out_free;

	logic              dm_done;
	weight_t           dm_weight;
	fix_t              dm_value;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;

	// A load fits when the table has room and the point lies above the last one.
	assign load_ok = (count_q != CNT_W'(TABLE_DEPTH))
		&& ((count_q == '0) || (req.position > last_q));

	assign mid    = lo_q + ((hi_q - lo_q) >> 1);
	assign rd_pos = rd_data[WORD_W-1:POS_W];
	assign rd_smp = rd_data[POS_W-1:0];

	// Read address: the probe point while searching, the lower neighbor after a miss.
	always_comb begin
		case (state_q)
			S_SRCH:  rd_addr = (lo_q < hi_q) ? mid : lo_q;
			S_HIT:   rd_addr = lo_q - 1'b1;
			default: rd_addr = lo_q;
		endcase
	end

	sgli_ram #(
		.WIDTH (WORD_W),
		.DEPTH (TABLE_DEPTH)
	) u_points (
		.clk     (clk),
		.wr_en   (accept && (req.kind == KIND_LOAD) && load_ok),
		.wr_addr (count_q[IDX_W-1:0]),
		.wr_data ({req.position, req.sample_value}),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	sgli_divmul u_divmul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_LOW),
		.num    (POS_W'(x_q - rd_pos)),
		.den    (POS_W'(up_pos_q - rd_pos)),
		.diff   ({up_smp_q[POS_W-1], up_smp_q} - {rd_smp[POS_W-1], rd_smp}),
		.base   (rd_smp),
		.done   (dm_done),
		.weight (dm_weight),
		.value  (dm_value)
	);

	// Control: sequencer, point count, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_free && (state_q == S_OUT)) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_OUT;
						case (req.kind)
							KIND_LOAD: begin
								if (load_ok) begin
									count_q <= count_q + 1'b1;
								end
							end
							KIND_CLEAR: count_q <= '0;
							KIND_QUERY: begin
								if ((count_q != '0) && (req.position >= first_q)
									&& (req.position <= last_q)) begin
									state_q <= S_SRCH;
								end
							end
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_SRCH:  state_q <= (lo_q < hi_q) ? S_SCMP : S_HIT;
				S_SCMP:  state_q <= S_SRCH;
				S_HIT:   state_q <= (rd_pos == x_q) ? S_OUT : S_LOW;
				S_LOW:   state_q <= S_DIV;
				S_DIV: begin
					if (dm_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath: span registers, search bounds, bracketing point, prepared result, output payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q          <= req.position;
			lo_q         <= '0;
			hi_q         <= IDX_W'(count_q - 1'b1);
			res_status_q <= ST_REJECTED;
			res_weight_q <= '0;
			res_value_q  <= '0;
			res_slot_q   <= '0;
			case (req.kind)
				KIND_LOAD: begin
					if (load_ok) begin
						res_status_q <= ST_LOADED;
						res_slot_q   <= 8'(count_q);
						last_q       <= req.position;
						if (count_q == '0) begin
							first_q <= req.position;
						end
					end
				end
				KIND_CLEAR: res_status_q <= ST_CLEARED;
				KIND_QUERY: begin
					if (count_q == '0) begin
						res_status_q <= ST_EMPTY;
					end else begin
						res_status_q <= ST_OUTRANGE;
					end
				end
				default: res_status_q <= ST_REJECTED;
			endcase
		end
		if (state_q == S_SRCH) begin
			mid_q <= mid;
		end
		// Narrow toward the first point at or above the query.
		if (state_q == S_SCMP) begin
			if (rd_pos >= x_q) begin
				hi_q <= mid_q;
			end else begin
				lo_q <= mid_q + 1'b1;
			end
		end
		if (state_q == S_HIT) begin
			up_pos_q <= rd_pos;
			up_smp_q <= rd_smp;
			if (rd_pos == x_q) begin
				res_status_q <= ST_EXACT;
				res_value_q  <= rd_smp;
				res_slot_q   <= 8'(lo_q);
			end
		end
		if ((state_q == S_DIV) && dm_done) begin
			res_status_q <= ST_INTERP;
			res_weight_q <= dm_weight;
			res_value_q  <= dm_value;
			res_slot_q   <= 8'(lo_q - 1'b1);
		end
		if ((state_q == S_OUT) && out_free) begin
			out_status_q <= res_status_q;
			out_weight_q <= res_weight_q;
			out_value_q  <= res_value_q;
			out_slot_q   <= res_slot_q;
		end
	end

	assign rsp.valid              = out_valid_q;
	assign rsp.status             = out_status_q;
	assign rsp.weight_fraction    = out_weight_q;
	assign rsp.interpolated_value = out_value_q;
	assign rsp.lower_slot         = out_slot_q;

	// The table never holds more points than it has slots.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("point count beyond table depth");

	// A clear empties the table on the next cycle.
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req.kind == KIND_CLEAR)) |=> (count_q == '0))
		else $error("clear did not empty the table");

	// The search bounds stay ordered and inside the loaded points.
	a_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_SRCH) || (state_q == S_SCMP))
		|-> ((lo_q <= hi_q) && (CNT_W'(hi_q) < count_q)))
		else $error("search bounds out of order");

	// The divider finishes only while a query waits on it.
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		dm_done |-> (state_q == S_DIV))
		else $error("divider done outside its wait state");
endmodule
`default_nettype wire
